// ----- rtl/core/masked_image_diff_accumulator_assert.svh -----
// Assertion macros for the image diff accumulator.
`ifndef MASKED_IMAGE_DIFF_ACCUMULATOR_ASSERT_SVH
`define MASKED_IMAGE_DIFF_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MIDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, checked during reset too.
`define MIDA_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mida_pkg.sv -----
`timescale 1ns / 1ps
package mida_pkg;

  localparam int CHAN_W      = 8;
  localparam int RATIO_W     = 17;
  localparam int COUNT_W     = 25;
  localparam int SUM_W       = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [RATIO_W-1:0] Q16_ONE = 17'h10000;

  typedef enum logic [1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_RATIO_LIMIT = 2'd1,
    CFG_BG_ENABLE   = 2'd2,
    CFG_BG_COLOR    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [CHAN_W-1:0] cheb;
    logic              surface;
    logic              above;
    logic              final_flag;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_SURF_GO,
    ST_SURF_WAIT,
    ST_FULL_GO,
    ST_FULL_WAIT,
    ST_EMIT
  } back_state_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- rtl/core/mida_front.sv -----
`timescale 1ns / 1ps
module mida_front (
  input  logic [7:0]      ref_red,
  input  logic [7:0]      ref_green,
  input  logic [7:0]      ref_blue,
  input  logic [7:0]      ref_alpha,
  input  logic [7:0]      test_red,
  input  logic [7:0]      test_green,
  input  logic [7:0]      test_blue,
  input  logic [7:0]      test_alpha,
  input  logic            final_pixel,
  input  logic [7:0]      channel_threshold,
  input  logic            background_enable,
  input  logic [31:0]     background_color,
  output mida_pkg::item_t item
);
  import mida_pkg::*;

  logic              transparent;
  logic              masked;
  logic              surface;
  logic [CHAN_W-1:0] d_r, d_g, d_b, d_a, m_rg, m_ba, dmax;

  assign transparent = (ref_alpha == '0) && (test_alpha == '0);
  assign masked = background_enable &&
                  ({ref_red, ref_green, ref_blue, ref_alpha} == background_color) &&
                  ({test_red, test_green, test_blue, test_alpha} == background_color);
  assign surface = !transparent && !masked;

  assign d_r  = abs_diff(ref_red,   test_red);
  assign d_g  = abs_diff(ref_green, test_green);
  assign d_b  = abs_diff(ref_blue,  test_blue);
  assign d_a  = abs_diff(ref_alpha, test_alpha);
  assign m_rg = (d_r > d_g) ? d_r : d_g;
  assign m_ba = (d_b > d_a) ? d_b : d_a;
  assign dmax = (m_rg > m_ba) ? m_rg : m_ba;

  always_comb begin
    item.cheb       = surface ? dmax : '0;
    item.surface    = surface;
    item.above      = surface && (dmax > channel_threshold);
    item.final_flag = final_pixel;
  end

endmodule

// ----- rtl/core/mida_queue.sv -----
`timescale 1ns / 1ps
module mida_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  mida_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd_en,
  output mida_pkg::item_t rd_item,
  output logic            not_empty
);
  import mida_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_wr, do_rd;

  assign full      = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      priority if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (do_rd && !do_wr) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_item;
  end

endmodule

// ----- rtl/core/mida_div.sv -----
`timescale 1ns / 1ps
module mida_div (
  input  logic               clk,
  input  logic               rst,
  input  mida_pkg::div_req_t req,
  output logic               done,
  output logic [16:0]        ratio
);
  import mida_pkg::*;

  localparam int NUM_W  = SUM_W + 16;
  localparam int BASE_W = COUNT_W + 8;
  localparam int DEN_W  = BASE_W + RATIO_W;

  logic [NUM_W-1:0]   rem;
  logic [DEN_W-1:0]   den;
  logic [RATIO_W:0]   quo;
  logic [4:0]         step;
  logic               busy;
  logic               zero_div;
  logic [BASE_W-1:0]  den_base;
  logic               ge;

  // count * 255
  assign den_base = {req.count, 8'b0} - BASE_W'(req.count);
  assign ge       = {{(DEN_W-NUM_W){1'b0}}, rem} >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 5'(RATIO_W);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= {req.sum, 16'b0};
      den      <= {den_base, {RATIO_W{1'b0}}};
      quo      <= '0;
      zero_div <= (req.count == '0);
    end else if (busy) begin
      if (ge) rem <= rem - den[NUM_W-1:0];
      quo <= {quo[RATIO_W-1:0], ge};
      den <= den >> 1;
    end
  end

  always_comb begin
    priority if (zero_div) ratio = '0;
    else if (quo[RATIO_W] || (quo[RATIO_W-1:0] > Q16_ONE)) ratio = Q16_ONE;
    else ratio = quo[RATIO_W-1:0];
  end

endmodule

// ----- rtl/core/mida_back.sv -----
`timescale 1ns / 1ps
module mida_back #(
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mida_pkg::item_t q_item,
  output logic            q_pop,
  input  logic [16:0]     surface_ratio_limit,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      distance,
  output logic            is_surface,
  output logic            done_res,
  output logic [16:0]     surface_ratio,
  output logic [16:0]     full_ratio,
  output logic [24:0]     surface_total,
  output logic            images_differ
);
  import mida_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = (PIXEL_COUNT_BITS >= COUNT_W) ?
      {COUNT_W{1'b1}} : COUNT_W'(64'd1 << PIXEL_COUNT_BITS);

  back_state_t        state, state_next;
  logic [COUNT_W-1:0] surface_count, pixel_count;
  logic [SUM_W-1:0]   distance_sum;
  logic [SUM_W:0]     sum_wide;
  logic [CHAN_W-1:0]  fin_dist;
  logic               fin_surface;
  logic [RATIO_W-1:0] sr;
  logic               out_valid, out_free, take, emit;
  div_req_t           div_req;
  logic               div_done;
  logic [RATIO_W-1:0] div_ratio;

  mida_div u_div (
    .clk   (clk),
    .rst   (rst),
    .req   (div_req),
    .done  (div_done),
    .ratio (div_ratio)
  );

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign sum_wide = {1'b0, distance_sum} + (SUM_W+1)'(q_item.cheb);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC:       if (take && q_item.final_flag) state_next = ST_SURF_GO;
      ST_SURF_GO:   state_next = ST_SURF_WAIT;
      ST_SURF_WAIT: if (div_done) state_next = ST_FULL_GO;
      ST_FULL_GO:   state_next = ST_FULL_WAIT;
      ST_FULL_WAIT: if (div_done) state_next = ST_EMIT;
      ST_EMIT:      if (out_free) state_next = ST_ACC;
      default:      state_next = ST_ACC;
    endcase
  end

  always_comb begin
    take          = 1'b0;
    emit          = 1'b0;
    div_req.start = 1'b0;
    div_req.sum   = distance_sum;
    div_req.count = surface_count;
    unique case (state)
      ST_ACC:     take = q_valid && out_free;
      ST_SURF_GO: div_req.start = 1'b1;
      ST_FULL_GO: begin
        div_req.start = 1'b1;
        div_req.count = pixel_count;
      end
      ST_EMIT:    emit = out_free;
      default:    ;
    endcase
    q_pop = take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_ACC;
      out_valid     <= 1'b0;
      surface_count <= '0;
      pixel_count   <= '0;
      distance_sum  <= '0;
    end else begin
      state <= state_next;
      if (take || emit) out_valid <= !(take && q_item.final_flag);
      else if (pop) out_valid <= 1'b0;
      if (take) begin
        if (pixel_count < COUNT_LIMIT) pixel_count <= pixel_count + 1'b1;
        if (q_item.surface && (surface_count < COUNT_LIMIT))
          surface_count <= surface_count + 1'b1;
        if (q_item.above) distance_sum <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      end else if (emit) begin
        surface_count <= '0;
        pixel_count   <= '0;
        distance_sum  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fin_dist    <= q_item.cheb;
      fin_surface <= q_item.surface;
    end
    if (state == ST_SURF_WAIT && div_done) sr <= div_ratio;
    if (take && !q_item.final_flag) begin
      distance      <= q_item.cheb;
      is_surface    <= q_item.surface;
      done_res      <= 1'b0;
      surface_ratio <= '0;
      full_ratio    <= '0;
      surface_total <= '0;
      images_differ <= 1'b0;
    end else if (emit) begin
      distance      <= fin_dist;
      is_surface    <= fin_surface;
      done_res      <= 1'b1;
      surface_ratio <= sr;
      full_ratio    <= div_ratio;
      surface_total <= surface_count;
      images_differ <= (sr >= surface_ratio_limit);
    end
  end

endmodule

// ----- rtl/core/masked_image_diff_accumulator.sv -----
`timescale 1ns / 1ps
// Compares a reference and a test RGBA image one pixel pair per word and
// returns one result word per pixel: its Chebyshev distance and whether it
// was compared. Pixels are classified on entry and placed in a four-deep
// queue; the back end accumulates counts and the thresholded distance sum
// and sustains one pixel per cycle while results are popped and no division
// runs. The pixel marked final additionally runs two 18-step restoring
// divisions on one shared divider to form the Q16 surface and full ratios,
// after which the accumulators clear. Configuration writes are accepted every
// cycle and must be issued while no pixel is in flight.
module masked_image_diff_accumulator #(
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ref_red,
  input  logic [7:0]  ref_green,
  input  logic [7:0]  ref_blue,
  input  logic [7:0]  ref_alpha,
  input  logic [7:0]  test_red,
  input  logic [7:0]  test_green,
  input  logic [7:0]  test_blue,
  input  logic [7:0]  test_alpha,
  input  logic        final_pixel,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  distance,
  output logic        is_surface,
  output logic        done_res,
  output logic [16:0] surface_ratio,
  output logic [16:0] full_ratio,
  output logic [24:0] surface_total,
  output logic        images_differ,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mida_pkg::*;

  logic [7:0]  channel_threshold;
  logic [16:0] surface_ratio_limit;
  logic        background_enable;
  logic [31:0] background_color;
  item_t       in_item, q_item;
  logic        q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_threshold   <= '0;
      surface_ratio_limit <= '0;
      background_enable   <= 1'b0;
      background_color    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_THRESHOLD:   channel_threshold   <= cfg_data[7:0];
        CFG_RATIO_LIMIT: surface_ratio_limit <= cfg_data[16:0];
        CFG_BG_ENABLE:   background_enable   <= cfg_data[0];
        CFG_BG_COLOR:    background_color    <= cfg_data;
      endcase
    end
  end

  mida_front u_front (
    .ref_red           (ref_red),
    .ref_green         (ref_green),
    .ref_blue          (ref_blue),
    .ref_alpha         (ref_alpha),
    .test_red          (test_red),
    .test_green        (test_green),
    .test_blue         (test_blue),
    .test_alpha        (test_alpha),
    .final_pixel       (final_pixel),
    .channel_threshold (channel_threshold),
    .background_enable (background_enable),
    .background_color  (background_color),
    .item              (in_item)
  );

  mida_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (push),
    .wr_item   (in_item),
    .full      (full),
    .rd_en     (q_pop),
    .rd_item   (q_item),
    .not_empty (q_valid)
  );

  mida_back #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .surface_ratio_limit (surface_ratio_limit),
    .empty               (empty),
    .pop                 (pop),
    .distance            (distance),
    .is_surface          (is_surface),
    .done_res            (done_res),
    .surface_ratio       (surface_ratio),
    .full_ratio          (full_ratio),
    .surface_total       (surface_total),
    .images_differ       (images_differ)
  );

endmodule

// ----- rtl/core/mida_checker.sv -----
`timescale 1ns / 1ps
`include "masked_image_diff_accumulator_assert.svh"
module mida_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  distance,
  input logic        is_surface,
  input logic        done_res,
  input logic [16:0] surface_ratio,
  input logic [16:0] full_ratio,
  input logic [24:0] surface_total,
  input logic        images_differ
);

  logic        mid_word;
  logic        skip_word;
  logic        flat_word;
  logic        summary_clear;
  logic [69:0] head_word;

  assign mid_word      = !empty && !done_res;
  assign skip_word     = !empty && !is_surface;
  assign flat_word     = !empty && done_res && (surface_total == 25'd0);
  assign summary_clear = (surface_ratio == 17'd0) && (full_ratio == 17'd0) &&
                         (surface_total == 25'd0) && !images_differ;
  assign head_word     = {distance, is_surface, done_res, surface_ratio, full_ratio,
                          surface_total, images_differ};

  `MIDA_ASSERT_ALWAYS(a_empty_after_reset, rst, empty, "result word present after reset")
  `MIDA_ASSERT_NOW(a_summary_zero, mid_word, summary_clear, "summary set on non-final word")
  `MIDA_ASSERT_NOW(a_skip_zero, skip_word, distance == 8'd0, "distance on skipped pixel")
  `MIDA_ASSERT_NOW(a_no_surface_ratio, flat_word, surface_ratio == 17'd0, "ratio without surface")
  `MIDA_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(head_word), "waiting word changed")

endmodule

bind masked_image_diff_accumulator mida_checker u_mida_checker (.*);
